### rtl/pcm24q_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcm24q_pkg;

    localparam int CODE_BITS = 24;
    localparam int FRAC_BITS = 23;

    // Numerator width of the shared divider and width of its step counter.
    localparam int NUM_W = CODE_BITS + 33;
    localparam int CNT_W = $clog2(34);

    localparam int ADDR_W = 3;
    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_SCALE_Q   = 1'b1;

    localparam logic [31:0] MAX_CODE   = 32'((64'd1 << (CODE_BITS - 1)) - 64'd1);
    localparam logic [31:0] DEN_UNPACK = 32'((64'd1 << CODE_BITS) - 64'd2);
    localparam logic [31:0] ONE_Q      = 32'(64'd1 << FRAC_BITS);
    localparam logic [CODE_BITS-1:0] MIN_CODE = CODE_BITS'(64'd1 << (CODE_BITS - 1));
    localparam logic [30:0] SCALE_RESET = 31'd8388608;
    localparam logic [32:0] SAT_NEG_MAG = 33'h080000000;
    localparam logic [32:0] SAT_POS     = 33'h07fffffff;

    typedef struct packed {
        logic signed [31:0]   sample;
        logic [CODE_BITS-1:0] code;
        logic                 restart;
    } t_in_item;

    typedef struct packed {
        logic [CODE_BITS-1:0] packed_code;
        logic signed [31:0]   sample_out;
        logic [31:0]          block_scale;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DLOAD,
        ST_DIV,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

### rtl/pcm24_scaled_quantizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Peak-normalised 24-bit PCM quantiser. One transaction in gives one transaction out. In pack
// mode a signed Q8.23 sample is divided by scale_q, clamped to plus or minus one and rounded
// to a code of CODE_BITS bits; in unpack mode a code is multiplied by scale_q / MAX_CODE and
// rounded to Q8.23 with saturation. A bit-serial shift-add multiplier and a restoring divider
// that yields one quotient bit per cycle do the work. A pack transaction runs the divider, or
// skips it when the sample is zero or clamps; an unpack transaction runs the CODE_BITS
// multiplier steps and then the 33 divider steps. The result waits in an output register,
// so the next transaction is taken while it is still stalled. The running peak is cleared
// by restart and reported as block_scale, floored at one (ONE_Q).
module pcm24_scaled_quantizer (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  pcm24q_pkg::t_in_item               i_in_item,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output pcm24q_pkg::t_out_item              o_out_item,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [pcm24q_pkg::ADDR_W-1:0]      paddr,
    input  wire  [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int CB = pcm24q_pkg::CODE_BITS;
    localparam int NW = pcm24q_pkg::NUM_W;
    localparam int CW = pcm24q_pkg::CNT_W;

    pcm24q_pkg::t_state    r_state, n_state;
    logic                  r_direction;
    logic [30:0]           r_scale_q;
    logic [31:0]           r_peak, n_peak;
    logic                  r_out_valid, n_out_valid;
    pcm24q_pkg::t_out_item r_out, n_out;

    logic [31:0]           r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic [31:0]           r_hi, n_hi;
    logic [CB-1:0]         r_lo, n_lo;
    logic [31:0]           r_rem, n_rem;
    logic [31:0]           r_den, n_den;
    logic [NW-1:0]         r_sh, n_sh;
    logic [32:0]           r_quo, n_quo;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [31:0]           r_bscale, n_bscale;

    logic                  in_acc;
    logic                  cfg_wr;
    logic [31:0]           smp_raw;
    logic [31:0]           smp_mag;
    logic [CB-1:0]         code_mag;
    logic [31:0]           peak_base;
    logic [31:0]           peak_new;
    logic [NW-1:0]         num;
    logic [32:0]           mul_sum;
    logic [32:0]           trial;
    logic                  trial_ge;
    logic [CB-1:0]         pack_code;
    logic [31:0]           unp_mag;
    logic [31:0]           unp_out;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign o_in_stall  = (r_state != pcm24q_pkg::ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        case (paddr[2])
            pcm24q_pkg::REG_DIRECTION: prdata = {31'd0, r_direction};
            pcm24q_pkg::REG_SCALE_Q:   prdata = {1'b0, r_scale_q};
            default:                   prdata = 32'd0;
        endcase
    end

    assign smp_raw   = i_in_item.sample;
    assign smp_mag   = smp_raw[31] ? (~smp_raw + 32'd1) : smp_raw;
    assign code_mag  = i_in_item.code[CB-1] ? (~i_in_item.code + CB'(1)) : i_in_item.code;
    assign peak_base = i_in_item.restart ? 32'd0 : r_peak;
    assign peak_new  = (smp_mag > peak_base) ? smp_mag : peak_base;

    assign num = r_direction
        ? ((NW'({r_hi, r_lo}) << 1) + NW'(pcm24q_pkg::MAX_CODE))
        : ((NW'(r_mag) << CB) - (NW'(r_mag) << 1) + NW'(r_scale_q));

    assign mul_sum  = {1'b0, r_hi} + (r_lo[0] ? {2'b0, r_scale_q} : 33'd0);
    assign trial    = {r_rem, r_sh[NW-1]};
    assign trial_ge = (trial >= {1'b0, r_den});

    assign pack_code = r_neg ? (~r_quo[CB-1:0] + CB'(1)) : r_quo[CB-1:0];

    always_comb begin
        if (r_neg) begin
            unp_mag = (r_quo > pcm24q_pkg::SAT_NEG_MAG) ? pcm24q_pkg::SAT_NEG_MAG[31:0]
                                                         : r_quo[31:0];
            unp_out = ~unp_mag + 32'd1;
        end else begin
            unp_mag = (r_quo > pcm24q_pkg::SAT_POS) ? pcm24q_pkg::SAT_POS[31:0] : r_quo[31:0];
            unp_out = unp_mag;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_peak      = r_peak;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_rem       = r_rem;
        n_den       = r_den;
        n_sh        = r_sh;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_bscale    = r_bscale;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pcm24q_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_mag    = smp_mag;
                    n_lo     = code_mag;
                    n_hi     = 32'd0;
                    n_neg    = r_direction ? i_in_item.code[CB-1] : smp_raw[31];
                    n_peak   = peak_new;
                    n_bscale = (peak_new < pcm24q_pkg::ONE_Q) ? pcm24q_pkg::ONE_Q : peak_new;
                    n_state  = pcm24q_pkg::ST_PREP;
                end
            end
            pcm24q_pkg::ST_PREP: begin
                if (r_direction) begin
                    n_cnt   = CW'(CB);
                    n_state = pcm24q_pkg::ST_MUL;
                end else if (r_mag == 32'd0) begin
                    n_quo   = 33'd0;
                    n_state = pcm24q_pkg::ST_FIN;
                end else if (r_mag >= {1'b0, r_scale_q}) begin
                    n_quo   = {1'b0, pcm24q_pkg::MAX_CODE};
                    n_state = pcm24q_pkg::ST_FIN;
                end else begin
                    n_rem   = 32'(num >> (CB - 1));
                    n_sh    = num << (NW - (CB - 1));
                    n_den   = {r_scale_q, 1'b0};
                    n_quo   = 33'd0;
                    n_cnt   = CW'(CB - 1);
                    n_state = pcm24q_pkg::ST_DIV;
                end
            end
            pcm24q_pkg::ST_MUL: begin
                n_hi  = mul_sum[32:1];
                n_lo  = {mul_sum[0], r_lo[CB-1:1]};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = pcm24q_pkg::ST_DLOAD;
                end
            end
            pcm24q_pkg::ST_DLOAD: begin
                n_rem   = 32'(num >> 33);
                n_sh    = num << (NW - 33);
                n_den   = pcm24q_pkg::DEN_UNPACK;
                n_quo   = 33'd0;
                n_cnt   = CW'(33);
                n_state = pcm24q_pkg::ST_DIV;
            end
            pcm24q_pkg::ST_DIV: begin
                n_rem = trial_ge ? 32'(trial - {1'b0, r_den}) : trial[31:0];
                n_sh  = r_sh << 1;
                n_quo = {r_quo[31:0], trial_ge};
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = pcm24q_pkg::ST_FIN;
                end
            end
            pcm24q_pkg::ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out.packed_code     = r_direction ? '0 : pack_code;
                    n_out.sample_out      = r_direction ? unp_out : 32'd0;
                    n_out.block_scale     = r_bscale;
                    n_state               = pcm24q_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pcm24q_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pcm24q_pkg::ST_IDLE;
            r_direction <= 1'b0;
            r_scale_q   <= pcm24q_pkg::SCALE_RESET;
            r_peak      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_peak      <= n_peak;
            r_out_valid <= n_out_valid;
            if (cfg_wr && (paddr[2] == pcm24q_pkg::REG_DIRECTION)) begin
                r_direction <= pwdata[0];
            end
            if (cfg_wr && (paddr[2] == pcm24q_pkg::REG_SCALE_Q)) begin
                r_scale_q <= pwdata[30:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_sh     <= n_sh;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_bscale <= n_bscale;
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == pcm24q_pkg::ST_PREP))
        else $error("accepted transaction did not start processing");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcm24q_pkg::ST_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_code_symmetric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.packed_code != pcm24q_pkg::MIN_CODE))
        else $error("packed code outside the symmetric range");

    a_scale_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.block_scale >= pcm24q_pkg::ONE_Q))
        else $error("block scale below one");
`endif

endmodule

`default_nettype wire
